@@ rtl/core/brlm_pkg.sv @@
// ----------------------------------------------------------------------------
// brlm_pkg
// Shared widths, constants and controller/datapath interface types for the
// block RMS level meter.
// ----------------------------------------------------------------------------
package brlm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int SQ_W     = 31;  // a square of a 16-bit sample is at most 2^30
  localparam int GAIN_W   = 4;
  localparam int LEVEL_W  = 17;
  localparam int RAD_W    = 32;  // radicand register, the mean padded to even width
  localparam int MEAN_W   = 31;  // the mean of squares is at most 2^30
  localparam int ROOT_W   = 16;
  localparam int REM_W    = 19;
  localparam int PROD_W   = ROOT_W + GAIN_W;
  localparam int SCALED_W = PROD_W + 1;

  localparam logic [GAIN_W-1:0]   GAIN_RESET = 4'd3;
  localparam logic [LEVEL_W-1:0]  FULL_SCALE = 17'h10000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // a sample transaction completes this cycle
    logic finish;     // fold the last square in and load the divider
    logic div_step;   // one restoring division step
    logic root_load;  // move the quotient into the root unit
    logic root_step;  // one square root step
    logic mul;        // scale the root by twice the gain
    logic out_load;   // write the result register
  } brlm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;       // the offered sample closes the block
    logic step_done;  // the iteration counter is on its final step
    logic out_free;   // the result register can take a new value
  } brlm_sts_t;

endpackage

@@ rtl/core/brlm_ctrl.sv @@
// ----------------------------------------------------------------------------
// brlm_ctrl
// Controller state machine: sequences accumulation, division, square root,
// scaling and result hand-off.
// ----------------------------------------------------------------------------
module brlm_ctrl
  import brlm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  brlm_sts_t sts,
  output brlm_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_ACC,
    S_FIN,
    S_DIV,
    S_RLOAD,
    S_ROOT,
    S_MUL,
    S_OUT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_stall_r;
  logic   accept;

  assign accept   = in_valid && !in_stall_r;
  assign in_stall = in_stall_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_ACC: begin
        if (accept && sts.last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN:   state_nxt = S_DIV;
      S_DIV: begin
        if (sts.step_done) begin
          state_nxt = S_RLOAD;
        end
      end
      S_RLOAD: state_nxt = S_ROOT;
      S_ROOT: begin
        if (sts.step_done) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL:   state_nxt = S_OUT;
      S_OUT: begin
        if (sts.out_free) begin
          state_nxt = S_ACC;
        end
      end
      default: state_nxt = S_ACC;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.accept    = accept;
    cmd.finish    = (state_r == S_FIN);
    cmd.div_step  = (state_r == S_DIV);
    cmd.root_load = (state_r == S_RLOAD);
    cmd.root_step = (state_r == S_ROOT);
    cmd.mul       = (state_r == S_MUL);
    cmd.out_load  = (state_r == S_OUT) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_ACC;
      in_stall_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= (state_nxt != S_ACC);
    end
  end

endmodule

@@ rtl/core/brlm_dp.sv @@
// ----------------------------------------------------------------------------
// brlm_dp
// Datapath: squaring and accumulation, bit-serial divider, digit-by-digit
// square root, gain scaling with clamp, and the result register.
// ----------------------------------------------------------------------------
module brlm_dp
  import brlm_pkg::*;
#(
  parameter int MAX_BLOCK = 4096
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  brlm_cmd_t                  cmd,
  output brlm_sts_t                  sts,
  input  logic signed [SAMPLE_W-1:0] in_sample_value,
  input  logic                       in_block_end,
  input  logic                       cfg_wr_en,
  input  logic [GAIN_W-1:0]          cfg_wr_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [LEVEL_W-1:0]         out_level,
  output logic                       out_clipped
);

  localparam int CNT_W  = $clog2(MAX_BLOCK + 1);
  localparam int SUM_W  = SQ_W - 1 + CNT_W;
  localparam int STEP_W = $clog2(SUM_W);

  localparam logic [CNT_W-1:0]  CNT_LAST   = CNT_W'(MAX_BLOCK - 1);
  localparam logic [STEP_W-1:0] DIV_FIRST  = STEP_W'(SUM_W - 1);
  localparam logic [STEP_W-1:0] ROOT_FIRST = STEP_W'(ROOT_W - 1);

  logic [GAIN_W-1:0]   gain_r;
  logic [SQ_W-1:0]     sq_r;
  logic [SUM_W-1:0]    sum_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [CNT_W-1:0]    dvs_r;
  logic [SUM_W-1:0]    dq_r;
  logic [CNT_W-1:0]    drem_r;
  logic [STEP_W-1:0]   step_r;
  logic [RAD_W-1:0]    rad_r;
  logic [REM_W-1:0]    rrem_r;
  logic [ROOT_W-1:0]   root_r;
  logic [SCALED_W-1:0] scaled_r;
  logic                out_valid_r;
  logic [LEVEL_W-1:0]  level_r;
  logic                clipped_r;

  logic signed [2*SAMPLE_W-1:0] sq_full;
  logic                         last;
  logic [CNT_W:0]               dtrial;
  logic                         dge;
  logic [REM_W-1:0]             rshift;
  logic [REM_W-1:0]             rtrial;
  logic                         rge;
  logic [PROD_W-1:0]            prod;
  logic                         over;

  assign sq_full = (2*SAMPLE_W)'(in_sample_value) * (2*SAMPLE_W)'(in_sample_value);
  assign last    = in_block_end || (cnt_r == CNT_LAST);

  // Restoring division: one quotient bit per step, shifted in from the right.
  assign dtrial = {drem_r, dq_r[SUM_W-1]};
  assign dge    = (dtrial >= {1'b0, dvs_r});

  // Square root: two radicand bits per step.
  assign rshift = {rrem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
  assign rtrial = {1'b0, root_r, 2'b01};
  assign rge    = (rshift >= rtrial);

  assign prod = PROD_W'(root_r) * PROD_W'(gain_r);
  assign over = (scaled_r > SCALED_W'(FULL_SCALE));

  assign sts.last      = last;
  assign sts.step_done = (step_r == '0);
  assign sts.out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r      <= GAIN_RESET;
      sq_r        <= '0;
      sum_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        gain_r <= cfg_wr_data;
      end
      // The square register reads zero whenever no sample was taken.
      sq_r  <= cmd.accept ? sq_full[SQ_W-1:0] : '0;
      sum_r <= cmd.finish ? '0 : sum_r + SUM_W'(sq_r);
      if (cmd.accept) begin
        cnt_r <= last ? '0 : cnt_r + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && last) begin
      dvs_r <= cnt_r + 1'b1;
    end
    if (cmd.finish) begin
      dq_r   <= sum_r + SUM_W'(sq_r);
      drem_r <= '0;
      step_r <= DIV_FIRST;
    end else if (cmd.div_step) begin
      dq_r   <= {dq_r[SUM_W-2:0], dge};
      drem_r <= dge ? CNT_W'(dtrial - {1'b0, dvs_r}) : dtrial[CNT_W-1:0];
      step_r <= step_r - 1'b1;
    end
    if (cmd.root_load) begin
      rad_r  <= {1'b0, dq_r[MEAN_W-1:0]};
      rrem_r <= '0;
      root_r <= '0;
      step_r <= ROOT_FIRST;
    end else if (cmd.root_step) begin
      rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
      rrem_r <= rge ? rshift - rtrial : rshift;
      root_r <= {root_r[ROOT_W-2:0], rge};
      step_r <= step_r - 1'b1;
    end
    if (cmd.mul) begin
      scaled_r <= {prod, 1'b0};
    end
    if (cmd.out_load) begin
      level_r   <= over ? FULL_SCALE : scaled_r[LEVEL_W-1:0];
      clipped_r <= over;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_level   = level_r;
  assign out_clipped = clipped_r;

endmodule

@@ rtl/core/block_rms_level_meter_unit.sv @@
// A result follows the sample that closes its block through the bit-serial divider
//   and the 16-step root.
// Throughput: one sample per cycle inside a block; after the closing sample the input
//   stalls until its result is written, which waits while the previous result is held.
// Reset (synchronous, active low) clears the sum, the count and the result valid,
//   and sets the gain to 3.
// ----------------------------------------------------------------------------
// block_rms_level_meter_unit
// Block RMS level meter: accumulates squared samples per block, then divides,
// takes the integer root, scales by twice the gain and clamps to full scale.
// ----------------------------------------------------------------------------
module block_rms_level_meter_unit
  import brlm_pkg::*;
#(
  parameter int MAX_BLOCK = 4096
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample_value,
  input  logic                       in_block_end,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [LEVEL_W-1:0]         out_level,
  output logic                       out_clipped,
  input  logic                       cfg_wr_en,
  input  logic [GAIN_W-1:0]          cfg_wr_data
);

  brlm_cmd_t cmd;
  brlm_sts_t sts;

  brlm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  brlm_dp #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_sample_value (in_sample_value),
    .in_block_end    (in_block_end),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_level       (out_level),
    .out_clipped     (out_clipped)
  );

`ifndef SYNTHESIS
  // A block-closing transaction must stop the input while the result is computed.
  a_end_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_block_end |=> in_stall)
    else $error("input not stalled after a block-closing transaction");

  a_clip_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |-> out_level == FULL_SCALE)
    else $error("clipped result is not at full scale");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_level <= FULL_SCALE)
    else $error("result level above full scale");
`endif

endmodule
